@@ rtl/fdcc_pkg.sv @@
// Package with constants, codes and the CRC byte update for the frame decoder.
`timescale 1ns / 1ps
`default_nettype none

package fdcc_pkg;

  localparam logic [15:0] CrcInit   = 16'hFFFF;
  localparam logic [15:0] CrcPoly   = 16'h1021;
  localparam int unsigned HeaderLen = 8;
  localparam int unsigned MinFrame  = 10;
  localparam int unsigned NumHdr    = 5;
  localparam int unsigned CountW    = 17;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  typedef enum logic [2:0] {
    StatOk        = 3'd0,
    StatShort     = 3'd1,
    StatPreamble  = 3'd2,
    StatOversize  = 3'd3,
    StatCount     = 3'd4,
    StatCrc       = 3'd5
  } status_e;

  typedef enum logic {
    RegPreamble   = 1'b0,
    RegMaxPayload = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    KindPayload = 1'b0,
    KindStatus  = 1'b1
  } kind_e;

  // CRC-16/CCITT-FALSE, one byte, MSB first
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/frame_decoder_crc16_check_unit.sv @@
// Byte-serial frame decoder with header capture and CRC-16 check.
// Results are registered; the output register frees in the cycle it is taken.
// Throughput: one byte per cycle, stalled while a held result waits on out_ready_i.
// The CRC byte update (eight unrolled shift steps) and the end-of-frame checks set the path.
// Reset: asynchronous, active low; clears frame state, output valid and the registers
// to preamble 0xAA and max payload 256.
`timescale 1ns / 1ps
`default_nettype none

module frame_decoder_crc16_check_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  // input bytes
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_frame_i,
  // results
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             kind_o,
  output logic [7:0]       payload_byte_o,
  output logic [15:0]      payload_index_o,
  output logic [2:0]       status_o,
  output logic [7:0]       version_byte_o,
  output logic [7:0]       hdr_type_o,
  output logic [7:0]       source_id_o,
  output logic [7:0]       dest_id_o,
  output logic [7:0]       flag_bits_o,
  output logic [15:0]      hdr_length_o,
  output logic [15:0]      frame_crc_o
);

  localparam int unsigned CW = fdcc_pkg::CountW;

  // configuration registers
  logic [7:0]  preamble_q;
  logic [15:0] max_payload_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preamble_q    <= 8'hAA;
      max_payload_q <= 16'd256;
    end else if (cfg_we_i) begin
      unique case (fdcc_pkg::cfg_reg_e'(cfg_idx_i))
        fdcc_pkg::RegPreamble:   preamble_q    <= cfg_data_i[7:0];
        fdcc_pkg::RegMaxPayload: max_payload_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // frame state
  logic [CW-1:0] count_q, count_d;
  logic [15:0]   crc_q, crc_d;
  logic [7:0]    first_q, first_d;
  logic [7:0]    hdr_q [fdcc_pkg::NumHdr];
  logic [7:0]    hdr_d [fdcc_pkg::NumHdr];
  logic [15:0]   len_q, len_d;
  logic [15:0]   rcrc_q, rcrc_d;

  // output register
  logic          out_valid_q, out_valid_d;
  logic          kind_q, kind_d;
  logic [7:0]    pbyte_q, pbyte_d;
  logic [15:0]   pidx_q, pidx_d;
  logic [2:0]    stat_q, stat_d;
  logic [7:0]    ohdr_q [fdcc_pkg::NumHdr];
  logic [7:0]    ohdr_d [fdcc_pkg::NumHdr];
  logic [15:0]   olen_q, olen_d;
  logic [15:0]   ocrc_q, ocrc_d;

  logic          accept;
  logic [CW-1:0] crc_end;
  logic          in_crc;
  logic          in_payload;
  logic [CW-1:0] n_cnt;
  logic [CW-1:0] exp_cnt;
  logic [15:0]   crc_upd;
  fdcc_pkg::status_e stat;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    first_d = (count_q == '0) ? data_byte_i : first_q;
    for (int i = 0; i < fdcc_pkg::NumHdr; i++) begin
      hdr_d[i] = (count_q == CW'(i + 1)) ? data_byte_i : hdr_q[i];
    end
    if (count_q == CW'(6)) begin
      len_d = {data_byte_i, 8'h00};
    end else if (count_q == CW'(7)) begin
      len_d = {len_q[15:8], data_byte_i};
    end else begin
      len_d = len_q;
    end

    crc_end    = {1'b0, len_d} + CW'(fdcc_pkg::HeaderLen);
    in_crc     = (count_q < CW'(fdcc_pkg::HeaderLen)) || (count_q < crc_end);
    in_payload = (count_q >= CW'(fdcc_pkg::HeaderLen)) && (count_q < crc_end);
    crc_upd    = fdcc_pkg::crc_byte(crc_q, data_byte_i);
    crc_d      = in_crc ? crc_upd : crc_q;
    rcrc_d     = {rcrc_q[7:0], data_byte_i};
    n_cnt      = (count_q != fdcc_pkg::CountMax) ? count_q + CW'(1) : count_q;
    count_d    = n_cnt;

    exp_cnt = {1'b0, len_d} + CW'(fdcc_pkg::MinFrame);
    priority if (n_cnt < CW'(fdcc_pkg::MinFrame)) begin
      stat = fdcc_pkg::StatShort;
    end else if (first_d != preamble_q) begin
      stat = fdcc_pkg::StatPreamble;
    end else if (len_d > max_payload_q) begin
      stat = fdcc_pkg::StatOversize;
    end else if (n_cnt != exp_cnt) begin
      stat = fdcc_pkg::StatCount;
    end else if (crc_d != rcrc_d) begin
      stat = fdcc_pkg::StatCrc;
    end else begin
      stat = fdcc_pkg::StatOk;
    end

    // result for this request
    kind_d  = fdcc_pkg::KindPayload;
    pbyte_d = '0;
    pidx_d  = '0;
    stat_d  = fdcc_pkg::StatOk;
    for (int i = 0; i < fdcc_pkg::NumHdr; i++) begin
      ohdr_d[i] = '0;
    end
    olen_d = '0;
    ocrc_d = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    if (accept) begin
      if (end_of_frame_i) begin
        out_valid_d = 1'b1;
        kind_d      = fdcc_pkg::KindStatus;
        stat_d      = stat;
        for (int i = 0; i < fdcc_pkg::NumHdr; i++) begin
          ohdr_d[i] = hdr_d[i];
        end
        olen_d = len_d;
        ocrc_d = rcrc_d;
      end else if (in_payload) begin
        out_valid_d = 1'b1;
        pbyte_d     = data_byte_i;
        pidx_d      = 16'(count_q - CW'(fdcc_pkg::HeaderLen));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      crc_q   <= fdcc_pkg::CrcInit;
      first_q <= '0;
      for (int i = 0; i < fdcc_pkg::NumHdr; i++) begin
        hdr_q[i] <= '0;
      end
      len_q  <= '0;
      rcrc_q <= '0;
    end else if (accept) begin
      if (end_of_frame_i) begin
        count_q <= '0;
        crc_q   <= fdcc_pkg::CrcInit;
        first_q <= '0;
        for (int i = 0; i < fdcc_pkg::NumHdr; i++) begin
          hdr_q[i] <= '0;
        end
        len_q  <= '0;
        rcrc_q <= '0;
      end else begin
        count_q <= count_d;
        crc_q   <= crc_d;
        first_q <= first_d;
        for (int i = 0; i < fdcc_pkg::NumHdr; i++) begin
          hdr_q[i] <= hdr_d[i];
        end
        len_q  <= len_d;
        rcrc_q <= rcrc_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_d;
      pbyte_q <= pbyte_d;
      pidx_q  <= pidx_d;
      stat_q  <= stat_d;
      for (int i = 0; i < fdcc_pkg::NumHdr; i++) begin
        ohdr_q[i] <= ohdr_d[i];
      end
      olen_q <= olen_d;
      ocrc_q <= ocrc_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign payload_byte_o  = pbyte_q;
  assign payload_index_o = pidx_q;
  assign status_o        = stat_q;
  assign version_byte_o  = ohdr_q[0];
  assign hdr_type_o      = ohdr_q[1];
  assign source_id_o     = ohdr_q[2];
  assign dest_id_o       = ohdr_q[3];
  assign flag_bits_o     = ohdr_q[4];
  assign hdr_length_o    = olen_q;
  assign frame_crc_o     = ocrc_q;

endmodule

`default_nettype wire
